[hw/rtl/yuyv2bgr_pkg.sv]
// Shared types and constants for the YUYV to BGR24 converter.
// No dependencies; imported by the interfaces and every module of the block.
package yuyv2bgr_pkg;

    localparam int BYTE_W = 8;

    // Q10 colour coefficients
    localparam int Q_SHIFT = 10;
    localparam int Q_Y     = 1192;
    localparam int Q_UB    = 1187;
    localparam int Q_VG    = 389;
    localparam int Q_UG    = 833;
    localparam int Q_VR    = 2066;
    localparam int Y_OFS   = 16;

    // signed width that holds every product and sum without overflow
    localparam int SUM_W = 21;

    typedef struct packed {
        logic [BYTE_W-1:0] luma_first;
        logic [BYTE_W-1:0] chroma_u;
        logic [BYTE_W-1:0] luma_second;
        logic [BYTE_W-1:0] chroma_v;
        logic              end_of_frame_in;
    } mpix_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_first;
        logic [BYTE_W-1:0] byte_middle;
        logic [BYTE_W-1:0] byte_last;
        logic              second_pixel;
        logic              end_of_frame;
    } pix_t;

    // one pixel's worth of work handed from the splitter to the pipeline
    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] chroma_u;
        logic [BYTE_W-1:0] chroma_v;
        logic              second_pixel;
        logic              end_of_frame;
    } lane_t;

endpackage

[hw/rtl/yuyv2bgr_if.sv]
// Valid/ready channel interfaces: macropixel input and pixel output.
// Depends on yuyv2bgr_pkg for the payload types.
interface yuyv2bgr_mpix_if
    import yuyv2bgr_pkg::*;
();
    logic  valid;
    logic  ready;
    mpix_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface yuyv2bgr_pix_if
    import yuyv2bgr_pkg::*;
();
    logic valid;
    logic ready;
    pix_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/yuyv2bgr_pixel_pipe.sv]
// Three-stage colour conversion pipeline for one pixel per beat.
// Depends on yuyv2bgr_pkg and yuyv2bgr_pix_if.
module yuyv2bgr_pixel_pipe
    import yuyv2bgr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_t                  lane,
    input  logic                   lane_valid,
    output logic                   lane_ready,
    yuyv2bgr_pix_if.source         pixel
);

    localparam logic signed [SUM_W-1:0] K_Y  = SUM_W'(Q_Y);
    localparam logic signed [SUM_W-1:0] K_UB = SUM_W'(Q_UB);
    localparam logic signed [SUM_W-1:0] K_VG = SUM_W'(Q_VG);
    localparam logic signed [SUM_W-1:0] K_UG = SUM_W'(Q_UG);
    localparam logic signed [SUM_W-1:0] K_VR = SUM_W'(Q_VR);
    localparam logic signed [SUM_W-1:0] K_YO = SUM_W'(Y_OFS);
    localparam logic [SUM_W-Q_SHIFT-1:0] BYTE_MAX = (SUM_W-Q_SHIFT)'(255);

    typedef struct packed {
        logic signed [SUM_W-1:0] l;
        logic signed [SUM_W-1:0] ub;
        logic signed [SUM_W-1:0] vg;
        logic signed [SUM_W-1:0] ug;
        logic signed [SUM_W-1:0] vr;
        logic                    second_pixel;
        logic                    end_of_frame;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] s_first;
        logic signed [SUM_W-1:0] s_middle;
        logic signed [SUM_W-1:0] s_last;
        logic                    second_pixel;
        logic                    end_of_frame;
    } sum_t;

    function automatic logic [BYTE_W-1:0] shift_clamp(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-Q_SHIFT-1:0] q;
        q = s[SUM_W-1:Q_SHIFT];
        if (s[SUM_W-1])
            return '0;
        else if (q > BYTE_MAX)
            return '1;
        else
            return q[BYTE_W-1:0];
    endfunction

    logic  v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic  rdy1, rdy2, rdy3;
    prod_t st1_reg, st1_next;
    sum_t  st2_reg, st2_next;
    pix_t  st3_reg, st3_next;

    logic signed [SUM_W-1:0] luma_s, cu_s, cv_s;

    assign rdy3       = !v3_reg || pixel.ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign lane_ready = rdy1;

    // U - 128 is the byte with its top bit flipped, read as signed
    always_comb
    begin
        luma_s = SUM_W'($signed({1'b0, lane.luma})) - K_YO;
        cu_s   = SUM_W'($signed({~lane.chroma_u[BYTE_W-1], lane.chroma_u[BYTE_W-2:0]}));
        cv_s   = SUM_W'($signed({~lane.chroma_v[BYTE_W-1], lane.chroma_v[BYTE_W-2:0]}));

        st1_next.l            = K_Y * luma_s;
        st1_next.ub           = K_UB * cu_s;
        st1_next.vg           = K_VG * cv_s;
        st1_next.ug           = K_UG * cu_s;
        st1_next.vr           = K_VR * cv_s;
        st1_next.second_pixel = lane.second_pixel;
        st1_next.end_of_frame = lane.end_of_frame;

        st2_next.s_first      = st1_reg.l + st1_reg.ub;
        st2_next.s_middle     = st1_reg.l - st1_reg.vg - st1_reg.ug;
        st2_next.s_last       = st1_reg.l + st1_reg.vr;
        st2_next.second_pixel = st1_reg.second_pixel;
        st2_next.end_of_frame = st1_reg.end_of_frame;

        st3_next.byte_first   = shift_clamp(st2_reg.s_first);
        st3_next.byte_middle  = shift_clamp(st2_reg.s_middle);
        st3_next.byte_last    = shift_clamp(st2_reg.s_last);
        st3_next.second_pixel = st2_reg.second_pixel;
        st3_next.end_of_frame = st2_reg.end_of_frame;
    end

    always_comb
    begin
        v1_next = rdy1 ? lane_valid : v1_reg;
        v2_next = rdy2 ? v1_reg     : v2_reg;
        v3_next = rdy3 ? v2_reg     : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            st1_reg <= st1_next;
        if (rdy2)
            st2_reg <= st2_next;
        if (rdy3)
            st3_reg <= st3_next;
    end

    assign pixel.valid = v3_reg;
    assign pixel.data  = st3_reg;

endmodule

[hw/rtl/yuyv_to_bgr24_converter_unit.sv]
// Top level of the YUYV to BGR24 converter: macropixel splitter plus pipeline.
// Depends on yuyv2bgr_pkg, yuyv2bgr_if and yuyv2bgr_pixel_pipe.
//
// Takes one YUYV macropixel (Y0, U, Y1, V, end-of-frame) per beat and gives two
// 24-bit pixels in B,G,R byte order, the Y0 pixel first, each byte clamped to
// 0..255; the end-of-frame mark rides on the second pixel only. The pixel
// channel carries one pixel per cycle when back-pressure does not stall it. A
// macropixel is held in a splitter register that feeds the three-stage
// arithmetic pipeline (products, sums, shift and clamp); the first pixel
// goes from the splitter register through the product, sum and clamp
// registers to the output, and the second follows it. Back-pressure stalls the stages without loss,
// and a new macropixel is taken while the second pixel of the last one leaves
// the splitter.
module yuyv_to_bgr24_converter_unit
    import yuyv2bgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    yuyv2bgr_mpix_if.sink     macropixel,
    yuyv2bgr_pix_if.source    pixel
);

    logic  s0_valid_reg, s0_valid_next;
    logic  s0_phase_reg, s0_phase_next;
    mpix_t s0_mpix_reg;
    logic  take;
    lane_t lane;
    logic  lane_ready;

    assign macropixel.ready = !s0_valid_reg || (s0_phase_reg && lane_ready);
    assign take             = macropixel.valid && macropixel.ready;

    always_comb
    begin
        lane.luma         = s0_phase_reg ? s0_mpix_reg.luma_second : s0_mpix_reg.luma_first;
        lane.chroma_u     = s0_mpix_reg.chroma_u;
        lane.chroma_v     = s0_mpix_reg.chroma_v;
        lane.second_pixel = s0_phase_reg;
        lane.end_of_frame = s0_phase_reg && s0_mpix_reg.end_of_frame_in;
    end

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        s0_phase_next = s0_phase_reg;
        if (take)
        begin
            s0_valid_next = 1'b1;
            s0_phase_next = 1'b0;
        end
        else if (s0_valid_reg && lane_ready)
        begin
            if (s0_phase_reg)
                s0_valid_next = 1'b0;
            else
                s0_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_phase_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s0_phase_reg <= s0_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s0_mpix_reg <= macropixel.data;
    end

    yuyv2bgr_pixel_pipe u_pipe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane       (lane),
        .lane_valid (s0_valid_reg),
        .lane_ready (lane_ready),
        .pixel      (pixel)
    );

endmodule

[hw/rtl/yuyv2bgr_checker.sv]
// Port-level checks for the YUYV to BGR24 converter, bound to the top level.
// Depends on yuyv2bgr_pkg; sees only the top level's channel signals.
module yuyv2bgr_checker
    import yuyv2bgr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input pix_t  out_data
);

    logic       in_take, out_take;
    logic       phase_reg, phase_next;
    logic [3:0] owed_reg, owed_next;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // expected pixel slot and pixels still owed for accepted macropixels
    always_comb
    begin
        phase_next = out_take ? !phase_reg : phase_reg;
        owed_next  = owed_reg + (in_take ? 4'd2 : 4'd0) - (out_take ? 4'd1 : 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            owed_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            owed_reg  <= owed_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("pixel beat changed while stalled");

    a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.second_pixel == phase_reg)
        else $error("pixels out of order");

    a_eof_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.second_pixel |-> !out_data.end_of_frame)
        else $error("end of frame on first pixel");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 4'd0)
        else $error("pixel without a macropixel");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= 4'd5)
        else $error("too many pixels in flight");

endmodule

bind yuyv_to_bgr24_converter_unit yuyv2bgr_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (macropixel.valid),
    .in_ready  (macropixel.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_data  (pixel.data)
);
